// ===== hdl/obrb_pkg.sv =====
// shared constants, request and status codes, and controller command struct
// for the offset addressed byte ring buffer; no dependencies
package obrb_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CAP_W   = 13;
  localparam int unsigned LVL_W   = 13;

  localparam int unsigned ARITH_W = ((FILL_W > CNT_W) ? FILL_W : CNT_W) + 1;

  localparam logic [FILL_W-1:0] CAP_RESET = (DEPTH < 4096) ? FILL_W'(DEPTH) : FILL_W'(4096);

  localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_EXPAND  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
  localparam logic [ST_W-1:0] ST_NODATA = 3'd2;
  localparam logic [ST_W-1:0] ST_NOROOM = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd4;

  typedef struct packed {
    logic load_req;
    logic execute;
    logic capture;
  } obrb_cmd_t;

  // index below cap plus a step of at most cap, wrapped at cap
  function automatic logic [IDX_W-1:0] wrap_add(input logic [ARITH_W-1:0] base,
                                               input logic [ARITH_W-1:0] step,
                                               input logic [ARITH_W-1:0] cap);
    logic [ARITH_W-1:0] sum;
    sum = base + step;
    if (sum >= cap) begin
      sum = sum - cap;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/obrb_ram.sv =====
// generic single port ram with registered read and read enable
// no dependencies
module obrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// ===== hdl/obrb_ctrl.sv =====
// sequencing state machine: accept, execute, capture into the output register
// depends on obrb_pkg
module obrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output obrb_pkg::obrb_cmd_t cmd_o
);
  import obrb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_CAPT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = S_CAPT;
      end
      S_CAPT: begin
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/obrb_dp.sv =====
// datapath: request registers, head/tail/fill/capacity, byte store, result register
// depends on obrb_pkg and obrb_ram
module obrb_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  obrb_pkg::obrb_cmd_t          cmd_i,
  input  logic                         cfg_we_i,
  input  logic [obrb_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic [obrb_pkg::REQ_W-1:0]   req_type_i,
  input  logic [obrb_pkg::DATA_W-1:0]  data_byte_i,
  input  logic [obrb_pkg::OFF_W-1:0]   offset_i,
  input  logic [obrb_pkg::CNT_W-1:0]   count_i,
  output logic [obrb_pkg::ST_W-1:0]    status_o,
  output logic [obrb_pkg::DATA_W-1:0]  read_byte_o,
  output logic [obrb_pkg::CNT_W-1:0]   amount_o,
  output logic [obrb_pkg::LVL_W-1:0]   fill_level_o
);
  import obrb_pkg::*;

  logic [REQ_W-1:0]  req_q;
  logic [DATA_W-1:0] data_q;
  logic [OFF_W-1:0]  off_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] cap_q, cap_d;

  logic [ST_W-1:0]   res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_amount_q, res_amount_d;
  logic              res_rd_q, res_rd_d;

  logic [ARITH_W-1:0] head_w, tail_w, fill_w, cap_w, off_w, cnt_w, cfg_w;
  logic [IDX_W-1:0]   pos;
  logic               ram_en, ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [DATA_W-1:0]  ram_rdata;

  assign head_w = ARITH_W'(head_q);
  assign tail_w = ARITH_W'(tail_q);
  assign fill_w = ARITH_W'(fill_q);
  assign cap_w  = ARITH_W'(cap_q);
  assign off_w  = ARITH_W'(off_q);
  assign cnt_w  = ARITH_W'(cnt_q);
  assign cfg_w  = ARITH_W'(cfg_data_i);

  assign pos = wrap_add(head_w, off_w, cap_w);

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_amount_d = res_amount_q;
    res_rd_d     = res_rd_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = pos;
    if (cfg_we_i) begin
      if (cfg_w == '0) begin
        cap_d = FILL_W'(1);
      end else if (cfg_w > ARITH_W'(DEPTH)) begin
        cap_d = FILL_W'(DEPTH);
      end else begin
        cap_d = FILL_W'(cfg_w);
      end
      head_d = '0;
      tail_d = '0;
      fill_d = '0;
    end else if (cmd_i.execute) begin
      res_status_d = ST_OK;
      res_amount_d = '0;
      res_rd_d     = 1'b0;
      case (req_q)
        REQ_APPEND: begin
          ram_addr = tail_q;
          if (fill_w >= cap_w) begin
            res_status_d = ST_FULL;
          end else begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            tail_d = wrap_add(tail_w, ARITH_W'(1), cap_w);
            fill_d = fill_q + FILL_W'(1);
          end
        end
        REQ_RELEASE: begin
          if (fill_w == '0 || fill_w < cnt_w) begin
            res_status_d = ST_NODATA;
          end else begin
            head_d       = wrap_add(head_w, cnt_w, cap_w);
            fill_d       = FILL_W'(fill_w - cnt_w);
            res_amount_d = cnt_q;
          end
        end
        REQ_READ: begin
          if (off_w >= fill_w) begin
            res_status_d = ST_RANGE;
          end else begin
            ram_en   = 1'b1;
            res_rd_d = 1'b1;
          end
        end
        REQ_WRITE: begin
          if (off_w >= cap_w) begin
            res_status_d = ST_RANGE;
          end else begin
            ram_en = 1'b1;
            ram_we = 1'b1;
          end
        end
        REQ_EXPAND: begin
          if (cnt_w > cap_w - fill_w) begin
            res_status_d = ST_NOROOM;
          end else begin
            tail_d       = wrap_add(tail_w, cnt_w, cap_w);
            fill_d       = FILL_W'(fill_w + cnt_w);
            res_amount_d = cnt_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  obrb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(data_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      cap_q  <= CAP_RESET;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      cap_q  <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= req_type_i;
      data_q <= data_byte_i;
      off_q  <= offset_i;
      cnt_q  <= count_i;
    end
    res_status_q <= res_status_d;
    res_amount_q <= res_amount_d;
    res_rd_q     <= res_rd_d;
    if (cmd_i.capture) begin
      status_o     <= res_status_q;
      read_byte_o  <= res_rd_q ? ram_rdata : '0;
      amount_o     <= res_amount_q;
      fill_level_o <= LVL_W'(fill_q);
    end
  end

endmodule

// ===== hdl/offset_addressed_byte_ring_buffer.sv =====
// top level of the offset addressed byte ring buffer
// depends on obrb_pkg, obrb_ctrl, obrb_dp (and obrb_ram below it)
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------------------
//   in        in_valid_i/in_ready_o   req_type_i data_byte_i offset_i count_i
//   out       out_valid_o/out_ready_i status_o read_byte_o amount_o fill_level_o
//   cfg       cfg_valid_i/cfg_ready_o cfg_data_i (capacity_in_use)
//
// one request at a time: accept, execute with one store access, capture
// the store is a single port ram; its registered read sets the capture step
// the next request is taken while the previous result waits in the output register
// reset clears head, tail and fill and sets the capacity to the full store
// a capacity write also empties the ring; the store keeps its contents
module offset_addressed_byte_ring_buffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [obrb_pkg::CAP_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [obrb_pkg::REQ_W-1:0]  req_type_i,
  input  logic [obrb_pkg::DATA_W-1:0] data_byte_i,
  input  logic [obrb_pkg::OFF_W-1:0]  offset_i,
  input  logic [obrb_pkg::CNT_W-1:0]  count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [obrb_pkg::ST_W-1:0]   status_o,
  output logic [obrb_pkg::DATA_W-1:0] read_byte_o,
  output logic [obrb_pkg::CNT_W-1:0]  amount_o,
  output logic [obrb_pkg::LVL_W-1:0]  fill_level_o
);
  import obrb_pkg::*;

  obrb_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  obrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  obrb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .offset_i    (offset_i),
    .count_i     (count_i),
    .status_o    (status_o),
    .read_byte_o (read_byte_o),
    .amount_o    (amount_o),
    .fill_level_o(fill_level_o)
  );

endmodule

// ===== tb/sv/obrb_result_checker.sv =====
// result checker for the offset addressed byte ring buffer: watches the config,
// request and result channels, predicts each result and compares it field by field
// depends on obrb_pkg
module obrb_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [obrb_pkg::CAP_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [obrb_pkg::REQ_W-1:0]  req_type_i,
  input  logic [obrb_pkg::DATA_W-1:0] data_byte_i,
  input  logic [obrb_pkg::OFF_W-1:0]  offset_i,
  input  logic [obrb_pkg::CNT_W-1:0]  count_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [obrb_pkg::ST_W-1:0]   status_i,
  input  logic [obrb_pkg::DATA_W-1:0] read_byte_i,
  input  logic [obrb_pkg::CNT_W-1:0]  amount_i,
  input  logic [obrb_pkg::LVL_W-1:0]  fill_level_i,
  output int                          errors_o,
  output int                          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import obrb_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] rd_byte;
    logic [CNT_W-1:0]  amount;
    logic [LVL_W-1:0]  level;
  } ring_result_t;

  logic [DATA_W-1:0] ring_mem [DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       ring_fill;
  int unsigned       ring_cap;
  ring_result_t      awaited_results [$];
  ring_result_t      want;
  ring_result_t      got;
  int                fail_count;

  function automatic int unsigned ring_step(input int unsigned base, input int unsigned step);
    int unsigned sum;
    sum = base + step;
    if (sum >= ring_cap) begin
      sum = sum - ring_cap;
    end
    return sum;
  endfunction

  function automatic ring_result_t ring_outcome(input logic [REQ_W-1:0] req,
                                                input logic [DATA_W-1:0] data,
                                                input int unsigned off,
                                                input int unsigned cnt);
    ring_result_t res;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_APPEND: begin
        if (ring_fill >= ring_cap) begin
          res.status = ST_FULL;
        end else begin
          ring_mem[IDX_W'(ring_tail)] = data;
          ring_tail = ring_step(ring_tail, 1);
          ring_fill = ring_fill + 1;
        end
      end
      REQ_RELEASE: begin
        if (ring_fill == 0 || ring_fill < cnt) begin
          res.status = ST_NODATA;
        end else begin
          ring_head = ring_step(ring_head, cnt);
          ring_fill = ring_fill - cnt;
          res.amount = CNT_W'(cnt);
        end
      end
      REQ_READ: begin
        if (off >= ring_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.rd_byte = ring_mem[IDX_W'(ring_step(ring_head, off))];
        end
      end
      REQ_WRITE: begin
        if (off >= ring_cap) begin
          res.status = ST_RANGE;
        end else begin
          ring_mem[IDX_W'(ring_step(ring_head, off))] = data;
        end
      end
      REQ_EXPAND: begin
        if (cnt > ring_cap - ring_fill) begin
          res.status = ST_NOROOM;
        end else begin
          ring_tail = ring_step(ring_tail, cnt);
          ring_fill = ring_fill + cnt;
          res.amount = CNT_W'(cnt);
        end
      end
      default: begin
      end
    endcase
    res.level = LVL_W'(ring_fill);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      ring_cap = DEPTH;
      awaited_results.delete();
      fail_count = 0;
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i == 0) begin
          ring_cap = 1;
        end else if (cfg_data_i > DEPTH) begin
          ring_cap = DEPTH;
        end else begin
          ring_cap = 32'(cfg_data_i);
        end
        ring_head = 0;
        ring_tail = 0;
        ring_fill = 0;
      end
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, read_byte_i, amount_i, fill_level_i};
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %p", $time, got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.rd_byte !== want.rd_byte) begin
            $display("%0t: read_byte expected %0h got %0h", $time, want.rd_byte, got.rd_byte);
            fail_count++;
          end
          if (got.amount !== want.amount) begin
            $display("%0t: amount expected %0d got %0d", $time, want.amount, got.amount);
            fail_count++;
          end
          if (got.level !== want.level) begin
            $display("%0t: fill_level expected %0d got %0d", $time, want.level, got.level);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(ring_outcome(req_type_i, data_byte_i, 32'(offset_i),
                                               32'(count_i)));
      end
      errors_o <= fail_count;
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// ===== tb/sv/offset_addressed_byte_ring_buffer_test.sv =====
// top of the byte ring buffer testbench: clock, reset, request and config stimulus,
// random stalls on both channels, watchdog and verdict
// depends on obrb_pkg, offset_addressed_byte_ring_buffer and obrb_result_checker
module offset_addressed_byte_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import obrb_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int QUIET_LIMIT = 2000;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] data_byte;
  logic [OFF_W-1:0]  offset;
  logic [CNT_W-1:0]  count;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] read_byte;
  logic [CNT_W-1:0]  amount;
  logic [LVL_W-1:0]  fill_level;
  int                errors;
  int                outstanding;

  bit                steady;
  int                sent;
  int                cap_writes;
  int                quiet_cycles;

  // stimulus-side view of the ring, used to keep reads on written bytes
  int unsigned       plan_cap = DEPTH;
  int unsigned       plan_head;
  int unsigned       plan_tail;
  int unsigned       plan_fill;
  bit                plan_written [DEPTH];

  offset_addressed_byte_ring_buffer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .data_byte_i  (data_byte),
    .offset_i     (offset),
    .count_i      (count),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .read_byte_o  (read_byte),
    .amount_o     (amount),
    .fill_level_o (fill_level)
  );

  obrb_result_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .req_type_i    (req_type),
    .data_byte_i   (data_byte),
    .offset_i      (offset),
    .count_i       (count),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .read_byte_i   (read_byte),
    .amount_i      (amount),
    .fill_level_i  (fill_level),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout at %0t after %0d cycles without a transfer", $time, quiet_cycles);
      $display("offset_addressed_byte_ring_buffer_test: errors");
      $finish;
    end
  end

  function automatic int unsigned plan_pos(input int unsigned base, input int unsigned step);
    int unsigned sum;
    sum = base + step;
    if (sum >= plan_cap) begin
      sum = sum - plan_cap;
    end
    return sum;
  endfunction

  function automatic void plan_apply(input logic [REQ_W-1:0] req, input int unsigned off,
                                     input int unsigned cnt);
    case (req)
      REQ_APPEND: begin
        if (plan_fill < plan_cap) begin
          plan_written[IDX_W'(plan_tail)] = 1'b1;
          plan_tail = plan_pos(plan_tail, 1);
          plan_fill = plan_fill + 1;
        end
      end
      REQ_RELEASE: begin
        if (plan_fill != 0 && cnt <= plan_fill) begin
          plan_head = plan_pos(plan_head, cnt);
          plan_fill = plan_fill - cnt;
        end
      end
      REQ_WRITE: begin
        if (off < plan_cap) begin
          plan_written[IDX_W'(plan_pos(plan_head, off))] = 1'b1;
        end
      end
      REQ_EXPAND: begin
        if (cnt <= plan_cap - plan_fill) begin
          plan_tail = plan_pos(plan_tail, cnt);
          plan_fill = plan_fill + cnt;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // a read that would land on a never written byte becomes a write there
  task automatic send(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data,
                      input logic [OFF_W-1:0] off, input logic [CNT_W-1:0] cnt);
    logic [REQ_W-1:0] kind;
    kind = req;
    if (kind == REQ_READ && off < plan_fill &&
        !plan_written[IDX_W'(plan_pos(plan_head, 32'(off)))]) begin
      kind = REQ_WRITE;
    end
    plan_apply(kind, 32'(off), 32'(cnt));
    in_valid <= 1'b1;
    req_type <= kind;
    data_byte <= data;
    offset <= off;
    count <= cnt;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!steady && $urandom_range(99) < 25) begin
      idle($urandom_range(3, 1));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
    plan_cap = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : 32'(value);
    plan_head = 0;
    plan_tail = 0;
    plan_fill = 0;
  endtask

  task automatic random_request();
    int unsigned      pick;
    int unsigned      free;
    int unsigned      small_room;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] off;
    logic [CNT_W-1:0] cnt;
    pick = $urandom_range(99);
    free = plan_cap - plan_fill;
    small_room = (free < 4) ? free : 4;
    off = OFF_W'($urandom_range(4095));
    cnt = CNT_W'($urandom_range(8191));
    if (pick < 30) begin
      req = REQ_APPEND;
    end else if (pick < 45) begin
      req = REQ_RELEASE;
      if ($urandom_range(99) < 80) begin
        cnt = CNT_W'($urandom_range(plan_fill));
      end
    end else if (pick < 70) begin
      req = REQ_READ;
      if (plan_fill > 0 && $urandom_range(99) < 80) begin
        off = OFF_W'($urandom_range(plan_fill - 1));
      end
    end else if (pick < 82) begin
      req = REQ_WRITE;
      if ($urandom_range(99) < 80) begin
        off = OFF_W'($urandom_range(plan_cap - 1));
      end
    end else if (pick < 92) begin
      req = REQ_EXPAND;
      pick = $urandom_range(99);
      if (pick < 70) begin
        cnt = CNT_W'($urandom_range(small_room));
      end else if (pick < 90) begin
        cnt = CNT_W'($urandom_range(free));
      end
    end else if (pick < 96) begin
      req = REQ_W'($urandom_range(7, 5));
    end else begin
      req = REQ_W'($urandom_range(7));
    end
    send(req, DATA_W'($urandom_range(255)), off, cnt);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [PHASES];
    phase_caps = '{13'd1, 13'd2, 13'd0, 13'd8191, 13'd3, 13'd4096, 13'd17, 13'd4097,
                   13'd64, 13'd5, 13'd0, 13'd0};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = '0;
    data_byte = '0;
    offset = '0;
    count = '0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: byte extremes, the read range bound, full and empty rings, unused request codes
    send(REQ_APPEND, 8'h00, 12'd0, 13'd0);
    send(REQ_APPEND, 8'hff, 12'd0, 13'd0);
    send(REQ_READ, 8'h00, 12'd0, 13'd0);
    send(REQ_READ, 8'h00, 12'd1, 13'd0);
    send(REQ_READ, 8'h00, 12'd2, 13'd0);
    send(REQ_READ, 8'h00, 12'd4095, 13'd0);
    send(REQ_WRITE, 8'h5a, 12'd4095, 13'd0);
    send(REQ_WRITE, 8'ha5, 12'd0, 13'd0);
    send(REQ_READ, 8'h00, 12'd0, 13'd0);
    send(REQ_RELEASE, 8'h00, 12'd0, 13'd0);
    send(REQ_RELEASE, 8'h00, 12'd0, 13'd8191);
    send(REQ_RELEASE, 8'h00, 12'd0, 13'd2);
    send(REQ_RELEASE, 8'h00, 12'd0, 13'd0);
    send(REQ_EXPAND, 8'h00, 12'd0, 13'd8191);
    send(REQ_EXPAND, 8'h00, 12'd0, 13'd4096);
    send(REQ_APPEND, 8'h11, 12'd0, 13'd0);
    send(REQ_EXPAND, 8'h00, 12'd0, 13'd1);
    send(REQ_READ, 8'h00, 12'd4093, 13'd0);
    send(REQ_READ, 8'h00, 12'd4095, 13'd0);
    send(REQ_WRITE, 8'hc3, 12'd4095, 13'd0);
    send(3'd5, 8'hff, 12'd4095, 13'd8191);
    send(3'd6, 8'h00, 12'd0, 13'd0);
    send(3'd7, 8'h3c, 12'd2048, 13'd4096);
    send(REQ_RELEASE, 8'h00, 12'd0, 13'd4096);
    send(REQ_EXPAND, 8'h00, 12'd0, 13'd0);

    for (int p = 0; p < PHASES; p++) begin
      if (p >= 10) begin
        phase_caps[p] = CAP_W'($urandom_range(300, 6));
      end
      set_capacity(phase_caps[p]);
      steady = (p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_request();
      end
    end
    steady = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("%0d requests sent over %0d capacity writes, from a single byte ring up to the",
             sent, cap_writes);
    $display("full store, with full, empty, range and room rejections and unused request codes");
    if (errors == 0 && outstanding == 0) begin
      $display("offset_addressed_byte_ring_buffer_test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, outstanding);
      $display("offset_addressed_byte_ring_buffer_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/obrb_pkg.sv
hdl/obrb_ram.sv
hdl/obrb_ctrl.sv
hdl/obrb_dp.sv
hdl/offset_addressed_byte_ring_buffer.sv
tb/sv/obrb_result_checker.sv
tb/sv/offset_addressed_byte_ring_buffer_test.sv
